@@ src/dense_matrix_multiply_accumulate_unit_assert.svh @@
// ----------------------------------------------------------------------------
// dense matrix multiply accumulate unit assertion macros
// concurrent checks on clk_i; DMMA_ASSERT is disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DENSE_MATRIX_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`define DENSE_MATRIX_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DMMA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DMMA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DMMA_ASSERT(name, prop, msg)
`define DMMA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

@@ src/dmma_pkg.sv @@
// ----------------------------------------------------------------------------
// dmma_pkg
// shared types, codes and arithmetic helpers of the matrix multiply unit
// ----------------------------------------------------------------------------
`default_nettype none
package dmma_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int DIM_W     = 5;
  localparam int IDX_W     = 4;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_IDX_W = 9;
  localparam int DEF_MAX_M = 16;
  localparam int DEF_MAX_K = 16;
  localparam int DEF_MAX_N = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 3'd0,
    CMD_WRITE_B = 3'd1,
    CMD_WRITE_C = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_READ_C  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_M  = 3'd0,
    CFG_INNER_K = 3'd1,
    CFG_COLS_N  = 3'd2,
    CFG_ALPHA   = 3'd3,
    CFG_BETA    = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WA,
    OP_WB,
    OP_WC,
    OP_RDC,
    OP_CLR,
    OP_MAC,
    OP_DOT,
    OP_MA,
    OP_MB,
    OP_WR,
    OP_LDRD,
    OP_LDDONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [DIM_W-1:0] i;
    logic [DIM_W-1:0] j;
    logic [DIM_W-1:0] l;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic signed [ACC_W-1:0] sat_add64(
    input logic signed [ACC_W-1:0] x,
    input logic signed [ACC_W-1:0] y
  );
    logic signed [ACC_W:0] s;
    s = {x[ACC_W-1], x} + {y[ACC_W-1], y};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add64 = s[ACC_W-1:0];
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] shr16_sat32(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [ACC_W-17:0] t;
    t = x[ACC_W-1:16];
    if (t[ACC_W-17:DATA_W-1] != {(ACC_W-16-DATA_W+1){t[DATA_W-1]}}) begin
      shr16_sat32 = t[ACC_W-17] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      shr16_sat32 = t[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ src/dmma_ram.sv @@
// ----------------------------------------------------------------------------
// dmma_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module dmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/dmma_datapath.sv @@
// ----------------------------------------------------------------------------
// dmma_datapath
// element stores, shared multiplier, saturating accumulator and result register
// ----------------------------------------------------------------------------
`default_nettype none
module dmma_datapath import dmma_pkg::*; #(
  parameter int MAX_M = DEF_MAX_M,
  parameter int MAX_K = DEF_MAX_K,
  parameter int MAX_N = DEF_MAX_N
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dp_ctrl_t                    ctrl_i,
  output dp_status_t                       status_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [DATA_W-1:0]           cfg_data_i,
  input  wire logic [IDX_W-1:0]            row_i,
  input  wire logic [IDX_W-1:0]            col_i,
  input  wire logic signed [DATA_W-1:0]    value_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic                             kind_o,
  output logic signed [DATA_W-1:0]         data_o
);

  localparam int RW = (MAX_M > 1) ? $clog2(MAX_M) : 1;
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int NW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int A_AW = RW + KW;
  localparam int B_AW = KW + NW;
  localparam int C_AW = RW + NW;

  logic [WIDE_IDX_W-1:0] row_w, col_w, i_w, j_w, l_w;
  logic                  row_m_ok, row_k_ok, col_k_ok, col_n_ok;

  logic signed [DATA_W-1:0] alpha_q, beta_q;
  logic signed [DATA_W-1:0] a_rd, b_rd, c_rd;
  logic                     c_we;
  logic [C_AW-1:0]          c_waddr, c_raddr;
  logic [DATA_W-1:0]        c_wdata;

  logic                     v1_q, v2_q;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0]  prod_q, mixa_q, acc_q;
  logic signed [DATA_W-1:0] dot_q;
  logic                     oob_q;
  logic                     out_v_q, kind_q;
  logic signed [DATA_W-1:0] data_q;

  assign row_w = {{(WIDE_IDX_W-IDX_W){1'b0}}, row_i};
  assign col_w = {{(WIDE_IDX_W-IDX_W){1'b0}}, col_i};
  assign i_w   = {{(WIDE_IDX_W-DIM_W){1'b0}}, ctrl_i.i};
  assign j_w   = {{(WIDE_IDX_W-DIM_W){1'b0}}, ctrl_i.j};
  assign l_w   = {{(WIDE_IDX_W-DIM_W){1'b0}}, ctrl_i.l};

  assign row_m_ok = row_w < WIDE_IDX_W'(MAX_M);
  assign row_k_ok = row_w < WIDE_IDX_W'(MAX_K);
  assign col_k_ok = col_w < WIDE_IDX_W'(MAX_K);
  assign col_n_ok = col_w < WIDE_IDX_W'(MAX_N);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= DATA_W'(65536);
      beta_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_BETA:  beta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dmma_ram #(.WIDTH(DATA_W), .DEPTH(2 ** A_AW)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.op == OP_WA && row_m_ok && col_k_ok),
    .waddr_i ({row_w[RW-1:0], col_w[KW-1:0]}),
    .wdata_i (value_i),
    .re_i    (ctrl_i.op == OP_MAC),
    .raddr_i ({i_w[RW-1:0], l_w[KW-1:0]}),
    .rdata_o (a_rd)
  );

  dmma_ram #(.WIDTH(DATA_W), .DEPTH(2 ** B_AW)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.op == OP_WB && row_k_ok && col_n_ok),
    .waddr_i ({row_w[KW-1:0], col_w[NW-1:0]}),
    .wdata_i (value_i),
    .re_i    (ctrl_i.op == OP_MAC),
    .raddr_i ({l_w[KW-1:0], j_w[NW-1:0]}),
    .rdata_o (b_rd)
  );

  always_comb begin
    if (ctrl_i.op == OP_WR) begin
      c_we    = 1'b1;
      c_waddr = {i_w[RW-1:0], j_w[NW-1:0]};
      c_wdata = shr16_sat32(sat_add64(mixa_q, prod_q));
    end else begin
      c_we    = (ctrl_i.op == OP_WC) && row_m_ok && col_n_ok;
      c_waddr = {row_w[RW-1:0], col_w[NW-1:0]};
      c_wdata = value_i;
    end
    if (ctrl_i.op == OP_RDC) begin
      c_raddr = {row_w[RW-1:0], col_w[NW-1:0]};
    end else begin
      c_raddr = {i_w[RW-1:0], j_w[NW-1:0]};
    end
  end

  dmma_ram #(.WIDTH(DATA_W), .DEPTH(2 ** C_AW)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (ctrl_i.op == OP_RDC || ctrl_i.op == OP_CLR),
    .raddr_i (c_raddr),
    .rdata_o (c_rd)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = a_rd;
    mul_b = b_rd;
    case (ctrl_i.op)
      OP_MA: begin
        mul_a = alpha_q;
        mul_b = dot_q;
      end
      OP_MB: begin
        mul_a = beta_q;
        mul_b = c_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.op == OP_MAC;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (ctrl_i.op == OP_CLR) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= sat_add64(acc_q, prod_q);
    end
    if (ctrl_i.op == OP_DOT) begin
      dot_q <= shr16_sat32(acc_q);
    end
    if (ctrl_i.op == OP_MB) begin
      mixa_q <= prod_q;
    end
    if (ctrl_i.op == OP_RDC) begin
      oob_q <= !(row_m_ok && col_n_ok);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ctrl_i.op == OP_LDRD || ctrl_i.op == OP_LDDONE) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LDRD) begin
      kind_q <= 1'b0;
      data_q <= oob_q ? '0 : c_rd;
    end else if (ctrl_i.op == OP_LDDONE) begin
      kind_q <= 1'b1;
      data_q <= '0;
    end
  end

  assign status_o.out_free = !out_v_q || !out_stall_i;
  assign out_valid_o       = out_v_q;
  assign kind_o            = kind_q;
  assign data_o            = data_q;

endmodule
`default_nettype wire

@@ src/dmma_controller.sv @@
// ----------------------------------------------------------------------------
// dmma_controller
// command decode and sequencer over the entries of c and the inner dimension
// ----------------------------------------------------------------------------
`default_nettype none
`include "dense_matrix_multiply_accumulate_unit_assert.svh"
module dmma_controller import dmma_pkg::*; #(
  parameter int MAX_M = DEF_MAX_M,
  parameter int MAX_K = DEF_MAX_K,
  parameter int MAX_N = DEF_MAX_N
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [CMD_W-1:0]     cmd_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  output dp_ctrl_t                  ctrl_o,
  input  wire dp_status_t           status_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MAC, S_DRAIN, S_DOT, S_MA, S_MB, S_WR, S_RD, S_DONE
  } state_e;

  state_e           state_q;
  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] m_eff, k_eff, n_eff;
  logic [DIM_W-1:0] i_q, j_q, l_q;
  logic             drain_q;
  logic             in_acc;

  assign m_eff = (WIDE_IDX_W'(rows_q) > WIDE_IDX_W'(MAX_M))  ? DIM_W'(MAX_M) : rows_q;
  assign k_eff = (WIDE_IDX_W'(inner_q) > WIDE_IDX_W'(MAX_K)) ? DIM_W'(MAX_K) : inner_q;
  assign n_eff = (WIDE_IDX_W'(cols_q) > WIDE_IDX_W'(MAX_N))  ? DIM_W'(MAX_N) : cols_q;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(16);
      inner_q <= DIM_W'(16);
      cols_q  <= DIM_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_M:  rows_q  <= cfg_data_i[DIM_W-1:0];
        CFG_INNER_K: inner_q <= cfg_data_i[DIM_W-1:0];
        CFG_COLS_N:  cols_q  <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl_o.op = OP_NONE;
    ctrl_o.i  = i_q;
    ctrl_o.j  = j_q;
    ctrl_o.l  = l_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_i)
            CMD_WRITE_A: ctrl_o.op = OP_WA;
            CMD_WRITE_B: ctrl_o.op = OP_WB;
            CMD_WRITE_C: ctrl_o.op = OP_WC;
            CMD_READ_C:  ctrl_o.op = OP_RDC;
            default: ;
          endcase
        end
      end
      S_CLR:   ctrl_o.op = OP_CLR;
      S_MAC:   ctrl_o.op = OP_MAC;
      S_DRAIN: ctrl_o.op = OP_NONE;
      S_DOT:   ctrl_o.op = OP_DOT;
      S_MA:    ctrl_o.op = OP_MA;
      S_MB:    ctrl_o.op = OP_MB;
      S_WR:    ctrl_o.op = OP_WR;
      S_RD:    ctrl_o.op = status_i.out_free ? OP_LDRD : OP_NONE;
      S_DONE:  ctrl_o.op = status_i.out_free ? OP_LDDONE : OP_NONE;
      default: ctrl_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      l_q     <= '0;
      drain_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && cmd_i == CMD_READ_C) begin
            state_q <= S_RD;
          end else if (in_acc && cmd_i == CMD_COMPUTE) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= (m_eff == '0 || n_eff == '0) ? S_DONE : S_CLR;
          end
        end
        S_CLR: begin
          l_q     <= '0;
          drain_q <= 1'b0;
          state_q <= (k_eff == '0) ? S_DRAIN : S_MAC;
        end
        S_MAC: begin
          if (l_q == k_eff - 1'b1) begin
            state_q <= S_DRAIN;
          end else begin
            l_q <= l_q + 1'b1;
          end
        end
        S_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            state_q <= S_DOT;
          end
        end
        S_DOT: state_q <= S_MA;
        S_MA:  state_q <= S_MB;
        S_MB:  state_q <= S_WR;
        S_WR: begin
          if (j_q == n_eff - 1'b1) begin
            j_q <= '0;
            if (i_q == m_eff - 1'b1) begin
              state_q <= S_DONE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_CLR;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_CLR;
          end
        end
        S_RD: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_DONE: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `DMMA_ASSERT(a_compute_start, (in_acc && cmd_i == CMD_COMPUTE) |=> (state_q == S_CLR || state_q == S_DONE), "compute did not start")
  `DMMA_ASSERT(a_mac_in_range, (state_q == S_MAC) |-> (l_q < k_eff), "inner index out of range")
  `DMMA_ASSERT(a_drain_len, (state_q == S_DRAIN && drain_q) |=> (state_q == S_DOT), "drain too long")
  `DMMA_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |-> (state_q == S_IDLE), "not idle in reset")

endmodule
`default_nettype wire

@@ src/dense_matrix_multiply_accumulate_unit.sv @@
// ----------------------------------------------------------------------------
// dense_matrix_multiply_accumulate_unit
// gemm engine, c = alpha * (a * b) + beta * c in q16.16
//
// requests enter on in_valid_i / in_stall_o with cmd, row, col and value;
// write requests for a, b and c give no result
// a read request gives one result (kind 0, element of c)
// a compute request walks every c entry in use, one entry after another
// (one shared multiplier: clear, k products, drain, alpha and beta products,
// write back), then gives one result of kind 1
// one request is worked on at a time; the next is taken once the
// previous result sits in the output register
// results leave on out_valid_o / out_stall_i; a stalled result holds and
// the block waits before it loads the next one
// reset leaves the block idle with m = k = n = 16, alpha = 1.0, beta = 0;
// store contents are undefined until written
// configuration is a plain write port that the block does not guard; the user writes it only while idle
// ----------------------------------------------------------------------------
`default_nettype none
module dense_matrix_multiply_accumulate_unit import dmma_pkg::*; #(
  parameter int MAX_M = DEF_MAX_M,
  parameter int MAX_K = DEF_MAX_K,
  parameter int MAX_N = DEF_MAX_N
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [CMD_W-1:0]         cmd_i,
  input  wire logic [IDX_W-1:0]         row_i,
  input  wire logic [IDX_W-1:0]         col_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          kind_o,
  output logic signed [DATA_W-1:0]      data_o
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  dmma_controller #(.MAX_M(MAX_M), .MAX_K(MAX_K), .MAX_N(MAX_N)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_o     (ctrl),
    .status_i   (status)
  );

  dmma_datapath #(.MAX_M(MAX_M), .MAX_K(MAX_K), .MAX_N(MAX_N)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .data_o      (data_o)
  );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dense matrix multiply accumulate unit. All
// three stores are preloaded, then the bench runs a few directed phases and
// a series of random phases. It drives the registers only while the unit is
// idle and keeps a local fixed point model of the stores. That model
// predicts every read and compute result, and each result is checked field
// by field in order. Both handshakes idle at random outside the no_idle phase.
// ----------------------------------------------------------------------------
module tb;
  import dmma_pkg::*;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;
  localparam int CMD_SPARE_FIRST = 5;
  localparam int CMD_SPARE_LAST = 7;
  localparam int STALL_PCT = 6;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;

  typedef struct {
    cmd_e cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct {
    logic kind;
    logic signed [DATA_W-1:0] data;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CMD_W-1:0] cmd_i = '0;
  logic [IDX_W-1:0] row_i = '0;
  logic [IDX_W-1:0] col_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic signed [DATA_W-1:0] data_o;

  dense_matrix_multiply_accumulate_unit u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic signed [31:0] mat_a[16][16];
  logic signed [31:0] mat_b[16][16];
  logic signed [31:0] mat_c[16][16];
  logic [4:0] dim_m = 5'd16;
  logic [4:0] dim_k = 5'd16;
  logic [4:0] dim_n = 5'd16;
  logic signed [31:0] alpha_q = Q_ONE;
  logic signed [31:0] beta_q = '0;
  bit no_idle = 1'b0;
  bit req_taken = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic logic signed [63:0] add_sat64(logic signed [63:0] x,
                                                   logic signed [63:0] y);
    logic signed [64:0] s;
    s = 65'(x) + 65'(y);
    if (s > 65'sh0_7fffffffffffffff) return 64'sh7fffffffffffffff;
    if (s < -65'sh0_8000000000000000) return 64'sh8000000000000000;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] rescale_q16(logic signed [63:0] x);
    logic signed [63:0] t;
    t = x >>> 16;
    if (t > 64'(Q_MAX)) return Q_MAX;
    if (t < 64'(Q_MIN)) return Q_MIN;
    return t[31:0];
  endfunction

  task automatic update_c_matrix();
    int m, k, n;
    logic signed [63:0] acc;
    logic signed [31:0] dot;
    m = dim_m > 16 ? 16 : dim_m;
    k = dim_k > 16 ? 16 : dim_k;
    n = dim_n > 16 ? 16 : dim_n;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int l = 0; l < k; l++)
          acc = add_sat64(acc, 64'(mat_a[i][l]) * 64'(mat_b[l][j]));
        dot = rescale_q16(acc);
        mat_c[i][j] = rescale_q16(add_sat64(64'(alpha_q) * 64'(dot),
                                            64'(beta_q) * 64'(mat_c[i][j])));
      end
    end
  endtask

  task automatic predict_request(req_t r);
    case (r.cmd)
      CMD_WRITE_A: mat_a[r.row][r.col] = r.value;
      CMD_WRITE_B: mat_b[r.row][r.col] = r.value;
      CMD_WRITE_C: mat_c[r.row][r.col] = r.value;
      CMD_COMPUTE: begin
        update_c_matrix();
        expected_rsps.push_back('{KIND_DONE, '0});
      end
      CMD_READ_C: expected_rsps.push_back('{KIND_READ, mat_c[r.row][r.col]});
      default: ;
    endcase
  endtask

  // input and output acceptance, checking, watchdog
  always @(posedge clk_i) begin
    req_t r;
    rsp_t e;
    req_taken = in_valid_i && !in_stall_o;
    if (req_taken) begin
      r.cmd = cmd_e'(cmd_i);
      r.row = row_i;
      r.col = col_i;
      r.value = value_i;
      predict_request(r);
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d data %0d", kind_o, data_o);
      end else begin
        e = expected_rsps.pop_front();
        if (kind_o !== e.kind || data_o !== e.data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d data %0d, got kind %0d data %0d",
                     e.kind, e.data, kind_o, data_o);
        end
      end
    end
    if (req_taken || (out_valid_o && !out_stall_i) || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  // request driver and result stall
  always @(negedge clk_i) begin
    req_t r;
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= STALL_PCT)) begin
          r = pending_reqs.pop_front();
          cmd_i <= r.cmd;
          row_i <= r.row;
          col_i <= r.col;
          value_i <= r.value;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < STALL_PCT);
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      6: return $urandom;
      7: return Q_MAX;
      8: return Q_MIN;
      9: return '0;
      default: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  task automatic queue_req(cmd_e cmd, int row, int col, logic signed [31:0] value);
    pending_reqs.push_back('{cmd, row[3:0], col[3:0], value});
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROWS_M: dim_m = data[4:0];
      CFG_INNER_K: dim_k = data[4:0];
      CFG_COLS_N: dim_n = data[4:0];
      CFG_ALPHA: alpha_q = data;
      CFG_BETA: beta_q = data;
      default: ;
    endcase
  endtask

  task automatic set_shape(int m, int k, int n, logic signed [31:0] alpha,
                           logic signed [31:0] beta);
    write_reg(CFG_ROWS_M, m);
    write_reg(CFG_INNER_K, k);
    write_reg(CFG_COLS_N, n);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_BETA, beta);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_dim();
    if ($urandom_range(9) == 0) return $urandom_range(31);
    return $urandom_range(1, 5);
  endfunction

  initial begin
    int sel;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every store entry so no read ever sees an unwritten one
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) begin
        queue_req(CMD_WRITE_A, i, j, pick_value());
        queue_req(CMD_WRITE_B, i, j, pick_value());
        queue_req(CMD_WRITE_C, i, j, pick_value());
      end
    end
    drain();

    // saturation at the extremes with a single entry
    set_shape(1, 1, 1, Q_MAX, Q_MIN);
    queue_req(CMD_WRITE_A, 0, 0, Q_MAX);
    queue_req(CMD_WRITE_B, 0, 0, Q_MAX);
    queue_req(CMD_WRITE_C, 0, 0, Q_MIN);
    queue_req(CMD_COMPUTE, 15, 15, Q_MAX);
    queue_req(CMD_READ_C, 0, 0, Q_MIN);
    queue_req(CMD_WRITE_A, 0, 0, Q_MIN);
    queue_req(CMD_WRITE_C, 0, 0, Q_MAX);
    queue_req(CMD_COMPUTE, 0, 0, '0);
    queue_req(CMD_READ_C, 0, 0, '0);
    queue_req(cmd_e'(CMD_SPARE_LAST), 15, 15, Q_MIN);
    queue_req(cmd_e'(CMD_SPARE_FIRST), 0, 0, Q_MAX);
    queue_req(CMD_READ_C, 15, 15, '1);
    drain();
    // no rows in use
    set_shape(0, 16, 16, Q_ONE, Q_ONE);
    queue_req(CMD_COMPUTE, 0, 0, '0);
    queue_req(CMD_READ_C, 0, 0, '0);
    drain();
    // empty inner dimension leaves beta times c
    set_shape(3, 0, 2, Q_ONE, -32'sh18000);
    queue_req(CMD_COMPUTE, 0, 0, '0);
    queue_req(CMD_READ_C, 2, 1, '0);
    drain();
    // oversized dimensions clamp to the full store
    set_shape(31, 17, 31, 32'sh8000, 32'sh4000);
    queue_req(CMD_COMPUTE, 0, 0, '0);
    queue_req(CMD_READ_C, 15, 15, '0);
    queue_req(CMD_READ_C, 7, 3, '0);
    drain();

    for (int p = 0; p < 8; p++) begin
      no_idle = (p == 3);
      set_shape(pick_dim(), pick_dim(), pick_dim(),
                p == 0 ? Q_MIN : pick_value(), p == 1 ? Q_MAX : pick_value());
      for (int n = 0; n < 100; n++) begin
        sel = $urandom_range(99);
        if (sel < 20) queue_req(CMD_WRITE_A, $urandom_range(15), $urandom_range(15),
                                pick_value());
        else if (sel < 40) queue_req(CMD_WRITE_B, $urandom_range(15), $urandom_range(15),
                                     pick_value());
        else if (sel < 55) queue_req(CMD_WRITE_C, $urandom_range(15), $urandom_range(15),
                                     pick_value());
        else if (sel < 60) queue_req(CMD_COMPUTE, $urandom_range(15), $urandom_range(15),
                                     $urandom);
        else if (sel < 96) queue_req(CMD_READ_C, $urandom_range(15), $urandom_range(15),
                                     $urandom);
        else queue_req(cmd_e'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                       $urandom_range(15), $urandom_range(15), $urandom);
      end
      drain();
    end
    no_idle = 1'b0;

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/dmma_pkg.sv
src/dmma_ram.sv
src/dmma_datapath.sv
src/dmma_controller.sv
src/dense_matrix_multiply_accumulate_unit.sv
tb/tb.sv
